/* hdl/bch_pkg.sv */
// Shared types and constants for the color histogram engine.
// No dependencies; imported by bch_orbit, bch_hist and the top level.
package bch_pkg;

    localparam int Z_W       = 32;   // Q4.28 orbit value, sign extended
    localparam int C_W       = 30;   // Q2.28 sample point
    localparam int PROD_W    = 64;
    localparam int FRAC_BITS = 28;
    localparam int CNT_W     = 32;
    localparam int LIM_W     = 11;
    localparam int IDX_W     = 18;
    localparam int N_W       = 16;   // orbit point count, ITER_MAX up to 65536
    localparam int CFG_IDX_W = 1;

    localparam logic FUNC_TRACE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LIMIT = 1'b1;

    typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} chan_t;

    typedef enum logic [1:0] {ORB_IDLE, ORB_MUL, ORB_UPD} orb_state_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TRACE, ST_REPLAY, ST_READ, ST_RESULT
    } top_state_t;

    typedef struct packed {
        logic           done;
        logic           escaped;
        logic [N_W-1:0] n;
    } orb_res_t;

    typedef struct packed {
        logic           start;
        chan_t          chan;
        logic [N_W-1:0] n;
    } rep_req_t;

endpackage

/* hdl/bch_orbit.sv */
// Orbit iterator: z = z*z + c in Q4.28, storing each point in the orbit memory.
// Depends on bch_pkg. The replay side reads the memory through a registered port.
module bch_orbit #(
    parameter int ITER_MAX = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [bch_pkg::C_W-1:0]      cr,
    input  logic signed [bch_pkg::C_W-1:0]      ci,
    output bch_pkg::orb_res_t                   res,
    input  logic [$clog2(ITER_MAX)-1:0]         rd_addr,
    output logic [bch_pkg::Z_W-1:0]             rd_re,
    output logic [bch_pkg::Z_W-1:0]             rd_im
);
    import bch_pkg::*;

    localparam int KW = $clog2(ITER_MAX + 1);
    localparam int AW = $clog2(ITER_MAX);
    localparam logic signed [PROD_W:0] ESC_LIM = (PROD_W + 1)'(4) <<< (2 * FRAC_BITS);

    orb_state_t state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic signed [Z_W-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [C_W-1:0] cr_reg, ci_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg;
    logic [2*Z_W-1:0] mem [ITER_MAX];
    logic [2*Z_W-1:0] rd_data_reg;

    logic signed [PROD_W:0] mag;
    logic signed [PROD_W-1:0] nr_full, ni_full;
    logic escape, wr_en;
    logic [KW-1:0] k_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ORB_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        if (start)
        begin
            cr_reg <= cr;
            ci_reg <= ci;
        end
        p_rr_reg <= zr_reg * zr_reg;
        p_ii_reg <= zi_reg * zi_reg;
        p_ri_reg <= zr_reg * zi_reg;
    end

    always_comb
    begin
        mag     = (PROD_W + 1)'(p_rr_reg) + (PROD_W + 1)'(p_ii_reg);
        // arithmetic shift gives floor; 2*zr*zi is one shift less
        nr_full = ((p_rr_reg - p_ii_reg) >>> FRAC_BITS) + PROD_W'(cr_reg);
        ni_full = (p_ri_reg >>> (FRAC_BITS - 1)) + PROD_W'(ci_reg);
        escape  = (k_reg != '0) && (mag > ESC_LIM);
        k_m1    = k_reg - 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        zr_next     = zr_reg;
        zi_next     = zi_reg;
        wr_en       = 1'b0;
        res         = '0;
        unique case (state_reg)
            ORB_IDLE:
            begin
                if (start)
                begin
                    k_next     = '0;
                    zr_next    = '0;
                    zi_next    = '0;
                    state_next = ORB_MUL;
                end
            end
            ORB_MUL:
            begin
                state_next = ORB_UPD;
            end
            ORB_UPD:
            begin
                if (escape)
                begin
                    res.done    = 1'b1;
                    res.escaped = 1'b1;
                    res.n       = N_W'(k_m1);
                    state_next  = ORB_IDLE;
                end
                else if (32'(k_reg) == 32'(ITER_MAX))
                begin
                    res.done   = 1'b1;
                    state_next = ORB_IDLE;
                end
                else
                begin
                    zr_next    = nr_full[Z_W-1:0];
                    zi_next    = ni_full[Z_W-1:0];
                    wr_en      = 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = ORB_MUL;
                end
            end
            default: state_next = ORB_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[k_reg[AW-1:0]] <= {nr_full[Z_W-1:0], ni_full[Z_W-1:0]};
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_re = rd_data_reg[2*Z_W-1:Z_W];
    assign rd_im = rd_data_reg[Z_W-1:0];

endmodule

/* hdl/bch_hist.sv */
// Histogram store: three counter memories, clearing sweep, bin reads and the
// orbit replay pipeline with read-modify-write forwarding. Depends on bch_pkg.
module bch_hist #(
    parameter int GRID_W   = 512,
    parameter int GRID_H   = 512,
    parameter int ITER_MAX = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    output logic                             clr_busy,
    input  logic                             rd_req,
    input  logic [bch_pkg::IDX_W-1:0]        rd_idx,
    output logic                             rd_valid,
    output logic [bch_pkg::CNT_W-1:0]        red,
    output logic [bch_pkg::CNT_W-1:0]        green,
    output logic [bch_pkg::CNT_W-1:0]        blue,
    input  bch_pkg::rep_req_t                rep,
    output logic                             rep_done,
    output logic [$clog2(ITER_MAX)-1:0]      orb_addr,
    input  logic [bch_pkg::Z_W-1:0]          orb_re,
    input  logic [bch_pkg::Z_W-1:0]          orb_im
);
    import bch_pkg::*;

    localparam int BINS  = GRID_W * GRID_H;
    localparam int BIN_W = $clog2(BINS);
    localparam int KW    = $clog2(ITER_MAX + 1);
    localparam int XP_W  = Z_W + $clog2(GRID_W + 1);
    localparam int YP_W  = Z_W + $clog2(GRID_H + 1);
    localparam int SH    = FRAC_BITS + 2;
    localparam logic signed [Z_W:0] OFFSET = (Z_W + 1)'(1) <<< (FRAC_BITS + 1);

    logic [CNT_W-1:0] mem_r [BINS];
    logic [CNT_W-1:0] mem_g [BINS];
    logic [CNT_W-1:0] mem_b [BINS];
    logic [CNT_W-1:0] rdata_r_reg, rdata_g_reg, rdata_b_reg;

    logic clr_busy_reg;
    logic [BIN_W-1:0] clr_addr_reg;

    logic rd_v_reg, rd_ok_reg;

    logic rep_act_reg;
    logic [KW-1:0] rep_k_reg;
    logic [N_W-1:0] rep_n_reg;
    chan_t rep_chan_reg;

    logic s1_v_reg, s2_v_reg, s3_v_reg;
    logic s2_negx_reg, s2_negy_reg;
    logic [XP_W-1:0] s2_px_reg;
    logic [YP_W-1:0] s2_py_reg;
    logic [BIN_W-1:0] s3_addr_reg;
    logic fw_v_reg;
    logic [BIN_W-1:0] fw_addr_reg;
    logic [CNT_W-1:0] fw_data_reg;

    logic issue;
    logic signed [Z_W:0] tx, ty;
    logic [XP_W-SH-1:0] px;
    logic [YP_W-SH-1:0] py;
    logic s2_ok;
    logic [BIN_W-1:0] bin, raddr, waddr;
    logic [31:0] idx32;
    logic [CNT_W-1:0] cur, inc, wdata;
    logic we_r, we_g, we_b;

    assign issue    = rep_act_reg && (32'(rep_k_reg) < 32'(rep_n_reg));
    assign orb_addr = rep_k_reg[$clog2(ITER_MAX)-1:0];
    assign rep_done = rep_act_reg && !issue && !s1_v_reg && !s2_v_reg && !s3_v_reg;
    assign clr_busy = clr_busy_reg;

    always_comb
    begin
        tx    = $signed({orb_re[Z_W-1], orb_re}) + OFFSET;
        ty    = $signed({orb_im[Z_W-1], orb_im}) + OFFSET;
        px    = s2_px_reg[XP_W-1:SH];
        py    = s2_py_reg[YP_W-1:SH];
        s2_ok = !s2_negx_reg && !s2_negy_reg
                && (32'(px) < 32'(GRID_W)) && (32'(py) < 32'(GRID_H));
        bin   = BIN_W'(py) * BIN_W'(GRID_W) + BIN_W'(px);
        idx32 = 32'(rd_idx);
        raddr = s2_v_reg ? bin : idx32[BIN_W-1:0];
        // previous write lands on the same edge as this read: take it directly
        case (rep_chan_reg)
            CH_RED:   cur = rdata_r_reg;
            CH_GREEN: cur = rdata_g_reg;
            default:  cur = rdata_b_reg;
        endcase
        if (fw_v_reg && (fw_addr_reg == s3_addr_reg))
            cur = fw_data_reg;
        inc   = (cur == '1) ? cur : cur + 1'b1;
        we_r  = clr_busy_reg || (s3_v_reg && rep_chan_reg == CH_RED);
        we_g  = clr_busy_reg || (s3_v_reg && rep_chan_reg == CH_GREEN);
        we_b  = clr_busy_reg || (s3_v_reg && rep_chan_reg == CH_BLUE);
        waddr = clr_busy_reg ? clr_addr_reg : s3_addr_reg;
        wdata = clr_busy_reg ? '0 : inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            rd_v_reg     <= 1'b0;
            rep_act_reg  <= 1'b0;
            rep_k_reg    <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            fw_v_reg     <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == BIN_W'(BINS - 1))
                    clr_busy_reg <= 1'b0;
            end
            rd_v_reg <= rd_req;
            if (rep.start)
            begin
                rep_act_reg <= 1'b1;
                rep_k_reg   <= '0;
            end
            else if (issue)
                rep_k_reg <= rep_k_reg + 1'b1;
            else if (rep_done)
                rep_act_reg <= 1'b0;
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg && s2_ok;
            fw_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rep.start)
        begin
            rep_n_reg    <= rep.n;
            rep_chan_reg <= rep.chan;
        end
        rd_ok_reg   <= idx32 < 32'(BINS);
        s2_negx_reg <= tx[Z_W];
        s2_negy_reg <= ty[Z_W];
        s2_px_reg   <= XP_W'(tx[Z_W-1:0]) * XP_W'(GRID_W);
        s2_py_reg   <= YP_W'(ty[Z_W-1:0]) * YP_W'(GRID_H);
        s3_addr_reg <= bin;
        fw_addr_reg <= s3_addr_reg;
        fw_data_reg <= inc;
    end

    always_ff @(posedge clk)
    begin
        if (we_r)
            mem_r[waddr] <= wdata;
        rdata_r_reg <= mem_r[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_g)
            mem_g[waddr] <= wdata;
        rdata_g_reg <= mem_g[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            mem_b[waddr] <= wdata;
        rdata_b_reg <= mem_b[raddr];
    end

    assign rd_valid = rd_v_reg;
    assign red      = rd_ok_reg ? rdata_r_reg : '0;
    assign green    = rd_ok_reg ? rdata_g_reg : '0;
    assign blue     = rd_ok_reg ? rdata_b_reg : '0;

endmodule

/* hdl/buddhabrot_color_histogram.sv */
// Color histogram engine: a trace item iterates z = z*z + c (Q4.28) for up to
// ITER_MAX steps, each through a multiply state and an update state; an escaping
// trace then replays the stored orbit into the chosen channel at one point per
// cycle through the replay pipeline. After reset the histograms are cleared in a
// sweep over all GRID_W*GRID_H bins, during which no item is taken. Items are
// handled one at a time; a result waits in the output register. Depends on
// bch_pkg, bch_orbit and bch_hist.
module buddhabrot_color_histogram #(
    parameter int GRID_W   = 512,
    parameter int GRID_H   = 512,
    parameter int ITER_MAX = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic signed [bch_pkg::C_W-1:0]    point_re,
    input  logic signed [bch_pkg::C_W-1:0]    point_im,
    input  logic [bch_pkg::IDX_W-1:0]         bin_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              escaped,
    output logic [bch_pkg::LIM_W-1:0]         escape_count,
    output logic [bch_pkg::CNT_W-1:0]         red_count,
    output logic [bch_pkg::CNT_W-1:0]         green_count,
    output logic [bch_pkg::CNT_W-1:0]         blue_count,
    input  logic                              cfg_we,
    input  logic [bch_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bch_pkg::LIM_W-1:0]         cfg_data
);
    import bch_pkg::*;

    top_state_t state_reg, state_next;
    logic [LIM_W-1:0] blue_limit_reg, green_limit_reg;
    logic res_esc_reg;
    logic [N_W-1:0] res_n_reg;
    logic [CNT_W-1:0] res_r_reg, res_g_reg, res_b_reg;
    logic out_valid_reg;

    orb_res_t orb_res;
    rep_req_t rep;
    logic rep_done, clr_busy, rd_valid, accept, orb_start, rd_req, load_out;
    logic [CNT_W-1:0] h_r, h_g, h_b;
    logic [$clog2(ITER_MAX)-1:0] orb_addr;
    logic [Z_W-1:0] orb_re, orb_im;

    bch_orbit #(.ITER_MAX(ITER_MAX)) u_orbit (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (orb_start),
        .cr      (point_re),
        .ci      (point_im),
        .res     (orb_res),
        .rd_addr (orb_addr),
        .rd_re   (orb_re),
        .rd_im   (orb_im)
    );

    bch_hist #(.GRID_W(GRID_W), .GRID_H(GRID_H), .ITER_MAX(ITER_MAX)) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_busy (clr_busy),
        .rd_req   (rd_req),
        .rd_idx   (bin_index),
        .rd_valid (rd_valid),
        .red      (h_r),
        .green    (h_g),
        .blue     (h_b),
        .rep      (rep),
        .rep_done (rep_done),
        .orb_addr (orb_addr),
        .orb_re   (orb_re),
        .orb_im   (orb_im)
    );

    assign in_stall  = (state_reg != ST_IDLE) || clr_busy;
    assign accept    = in_valid && !in_stall;
    assign orb_start = accept && (func == FUNC_TRACE);
    assign rd_req    = accept && (func == FUNC_READ);
    assign load_out  = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        rep        = '0;
        rep.n      = orb_res.n;
        if (32'(orb_res.n) <= 32'(blue_limit_reg))
            rep.chan = CH_BLUE;
        else if (32'(orb_res.n) <= 32'(green_limit_reg))
            rep.chan = CH_GREEN;
        else
            rep.chan = CH_RED;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (orb_start)
                    state_next = ST_TRACE;
                else if (rd_req)
                    state_next = ST_READ;
            end
            ST_TRACE:
            begin
                if (orb_res.done)
                begin
                    rep.start  = orb_res.escaped;
                    state_next = orb_res.escaped ? ST_REPLAY : ST_RESULT;
                end
            end
            ST_REPLAY:
            begin
                if (rep_done)
                    state_next = ST_RESULT;
            end
            ST_READ:
            begin
                if (rd_valid)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            blue_limit_reg  <= LIM_W'(20);
            green_limit_reg <= LIM_W'(200);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BLUE_LIMIT:  blue_limit_reg  <= cfg_data;
                    CFG_GREEN_LIMIT: green_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_esc_reg <= 1'b0;
            res_n_reg   <= '0;
            res_r_reg   <= '0;
            res_g_reg   <= '0;
            res_b_reg   <= '0;
        end
        if (state_reg == ST_TRACE && orb_res.done && orb_res.escaped)
        begin
            res_esc_reg <= 1'b1;
            res_n_reg   <= orb_res.n;
        end
        if (state_reg == ST_READ && rd_valid)
        begin
            res_r_reg <= h_r;
            res_g_reg <= h_g;
            res_b_reg <= h_b;
        end
        if (load_out)
        begin
            escaped      <= res_esc_reg;
            escape_count <= res_n_reg[LIM_W-1:0];
            red_count    <= res_r_reg;
            green_count  <= res_g_reg;
            blue_count   <= res_b_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !clr_busy)
        else $error("item accepted during histogram clear");

    a_replay_only_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        rep_done |-> (state_reg == ST_REPLAY))
        else $error("replay finished outside replay state");

    a_orbit_done_in_trace: assert property (@(posedge clk) disable iff (!rst_n)
        orb_res.done |-> (state_reg == ST_TRACE))
        else $error("orbit finished outside trace state");

    a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_RESULT))
        else $error("result shown without a finished item");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for buddhabrot_color_histogram: directed table, then random
// traces and bin reads, checked against a sparse histogram predictor.
// Depends on bch_pkg and the buddhabrot_color_histogram top level.
module tb_top;
    import bch_pkg::*;

    localparam int  GW = 512;
    localparam int  GH = 512;
    localparam int  ITER = 1024;
    localparam int  WATCH_LIMIT = 2000000;
    localparam logic signed [C_W-1:0] P_MAX = 30'sh1FFFFFFF;
    localparam logic signed [C_W-1:0] P_MIN = 30'sh20000000;
    localparam logic signed [C_W-1:0] P_ONE = 30'sh10000000;

    typedef struct {
        logic             esc;
        logic [LIM_W-1:0] cnt;
        logic [CNT_W-1:0] r, g, b;
    } hist_res_t;

    typedef struct {
        logic                    f;
        logic signed [C_W-1:0]   re, im;
        logic [IDX_W-1:0]        idx;
        bit                      known;
        hist_res_t               res;
    } stim_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic func = FUNC_TRACE;
    logic signed [C_W-1:0] point_re = '0;
    logic signed [C_W-1:0] point_im = '0;
    logic [IDX_W-1:0] bin_index = '0;
    logic out_valid;
    logic out_stall = 0;
    logic escaped;
    logic [LIM_W-1:0] escape_count;
    logic [CNT_W-1:0] red_count, green_count, blue_count;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIM_W-1:0] cfg_data = '0;

    buddhabrot_color_histogram #(.GRID_W(GW), .GRID_H(GH), .ITER_MAX(ITER)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .point_re(point_re), .point_im(point_im), .bin_index(bin_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .escaped(escaped), .escape_count(escape_count),
        .red_count(red_count), .green_count(green_count), .blue_count(blue_count),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [CNT_W-1:0] red_h[int];
    logic [CNT_W-1:0] green_h[int];
    logic [CNT_W-1:0] blue_h[int];
    int hot_bins[$];
    logic [LIM_W-1:0] blue_lim = 11'd20;
    logic [LIM_W-1:0] green_lim = 11'd200;

    hist_res_t pending_q[$];
    int errors = 0;
    int tx_pct = 0;
    int rx_pct = 0;
    bit hold_req = 0;

    function automatic longint grid_coord(longint x, int size);
        longint t, p;
        t = x + (longint'(1) << (FRAC_BITS + 1));
        if (t < 0)
            return -1;
        p = (t * size) >>> (FRAC_BITS + 2);
        if (p >= size)
            return -1;
        return p;
    endfunction

    function automatic void bump_bin(chan_t ch, int b);
        if (!red_h.exists(b) && !green_h.exists(b) && !blue_h.exists(b))
            hot_bins.push_back(b);
        if (!red_h.exists(b)) red_h[b] = '0;
        if (!green_h.exists(b)) green_h[b] = '0;
        if (!blue_h.exists(b)) blue_h[b] = '0;
        case (ch)
            CH_RED:   if (red_h[b] != '1) red_h[b] = red_h[b] + 1;
            CH_GREEN: if (green_h[b] != '1) green_h[b] = green_h[b] + 1;
            default:  if (blue_h[b] != '1) blue_h[b] = blue_h[b] + 1;
        endcase
    endfunction

    function automatic hist_res_t trace_point(logic signed [C_W-1:0] cr_v,
                                              logic signed [C_W-1:0] ci_v);
        hist_res_t r;
        longint cr, ci, zr, zi, nr, ni, px, py;
        longint orb_r[ITER];
        longint orb_i[ITER];
        int n;
        bit esc;
        chan_t ch;
        r = '{default: '0};
        cr = cr_v;
        ci = ci_v;
        zr = 0;
        zi = 0;
        esc = 0;
        n = 0;
        for (int k = 0; k < ITER; k++) begin
            nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
            ni = ((2 * zr * zi) >>> FRAC_BITS) + ci;
            zr = nr;
            zi = ni;
            orb_r[k] = zr;
            orb_i[k] = zi;
            if (zr * zr + zi * zi > (longint'(4) << (2 * FRAC_BITS))) begin
                esc = 1;
                n = k;
                break;
            end
        end
        if (!esc)
            return r;
        if (n <= blue_lim)
            ch = CH_BLUE;
        else if (n <= green_lim)
            ch = CH_GREEN;
        else
            ch = CH_RED;
        for (int k = 0; k < n; k++) begin
            px = grid_coord(orb_r[k], GW);
            py = grid_coord(orb_i[k], GH);
            if (px >= 0 && py >= 0)
                bump_bin(ch, int'(py * GW + px));
        end
        r.esc = 1;
        r.cnt = n[LIM_W-1:0];
        return r;
    endfunction

    function automatic hist_res_t read_bin(logic [IDX_W-1:0] idx);
        hist_res_t r;
        int b;
        r = '{default: '0};
        b = int'(idx);
        if (b < GW * GH) begin
            if (red_h.exists(b)) r.r = red_h[b];
            if (green_h.exists(b)) r.g = green_h[b];
            if (blue_h.exists(b)) r.b = blue_h[b];
        end
        return r;
    endfunction

    function automatic stim_row_t row(logic f, logic signed [C_W-1:0] re,
                                      logic signed [C_W-1:0] im, logic [IDX_W-1:0] idx,
                                      bit known, logic esc, logic [LIM_W-1:0] cnt,
                                      logic [CNT_W-1:0] rc, logic [CNT_W-1:0] gc,
                                      logic [CNT_W-1:0] bc);
        stim_row_t s;
        s.f = f;
        s.re = re;
        s.im = im;
        s.idx = idx;
        s.known = known;
        s.res.esc = esc;
        s.res.cnt = cnt;
        s.res.r = rc;
        s.res.g = gc;
        s.res.b = bc;
        return s;
    endfunction

    task automatic send_item(stim_row_t s);
        hist_res_t r;
        in_valid <= 1;
        func <= s.f;
        point_re <= s.re;
        point_im <= s.im;
        bin_index <= s.idx;
        do @(posedge clk); while (in_stall);
        if (s.f == FUNC_READ)
            r = read_bin(s.idx);
        else
            r = trace_point(s.re, s.im);
        if (s.known)
            r = s.res;
        pending_q.push_back(r);
        if ($urandom_range(99) < tx_pct) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_limits(logic [LIM_W-1:0] bl, logic [LIM_W-1:0] gl);
        cfg_we <= 1;
        cfg_index <= CFG_BLUE_LIMIT;
        cfg_data <= bl;
        @(posedge clk);
        cfg_index <= CFG_GREEN_LIMIT;
        cfg_data <= gl;
        @(posedge clk);
        cfg_we <= 0;
        blue_lim = bl;
        green_lim = gl;
        @(posedge clk);
    endtask

    function automatic stim_row_t rand_item(bit force_read);
        stim_row_t s;
        s = row(FUNC_TRACE, $urandom(), $urandom(), $urandom(), 0, 0, 0, 0, 0, 0);
        if (force_read || $urandom_range(99) < 40) begin
            s.f = FUNC_READ;
            if (hot_bins.size() != 0 && $urandom_range(99) < 70)
                s.idx = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
        end else if ($urandom_range(99) < 70) begin
            // box around the set where orbits run long
            s.re = $signed($urandom_range(0, 671088640)) - 536870912;
            s.im = $signed($urandom_range(0, 671088640)) - 335544320;
        end
        return s;
    endfunction

    // receiver: checks each result item, drives out_stall
    initial begin
        int hold_cnt;
        hist_res_t e;
        hold_cnt = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                if (pending_q.size() == 0) begin
                    $display("%0t unexpected result item", $time);
                    errors++;
                end else begin
                    e = pending_q.pop_front();
                    if (escaped !== e.esc) begin
                        $display("%0t escaped exp %0d act %0d", $time, e.esc, escaped);
                        errors++;
                    end
                    if (escape_count !== e.cnt) begin
                        $display("%0t escape_count exp %0d act %0d", $time, e.cnt,
                                 escape_count);
                        errors++;
                    end
                    if (red_count !== e.r) begin
                        $display("%0t red_count exp %0d act %0d", $time, e.r, red_count);
                        errors++;
                    end
                    if (green_count !== e.g) begin
                        $display("%0t green_count exp %0d act %0d", $time, e.g,
                                 green_count);
                        errors++;
                    end
                    if (blue_count !== e.b) begin
                        $display("%0t blue_count exp %0d act %0d", $time, e.b,
                                 blue_count);
                        errors++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_stall <= 1;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = 600;
                out_stall <= 1;
            end else begin
                out_stall <= ($urandom_range(99) < rx_pct);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCH_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t dir_tab[$];
        int bin_z1;
        bin_z1 = 256 * GW + 511;
        dir_tab.push_back(row(FUNC_READ, 0, 0, 18'd0, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_READ, P_MAX, P_MIN, 18'h3FFFF, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, 0, 0, 18'h3FFFF, 1, 0, 0, 0, 0, 0));
        // c = -2 lands on the fixed point 2, bounded forever
        dir_tab.push_back(row(FUNC_TRACE, P_MIN, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, -P_ONE, 0, 0, 1, 0, 0, 0, 0, 0));
        // corners escape on the first point: count zero, nothing binned
        dir_tab.push_back(row(FUNC_TRACE, P_MAX, P_MAX, 0, 1, 1, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, P_MIN, P_MIN, 0, 1, 1, 0, 0, 0, 0));
        // one bounded point at the right grid edge, blue
        dir_tab.push_back(row(FUNC_TRACE, P_MAX, 0, 0, 1, 1, 1, 0, 0, 0));
        dir_tab.push_back(row(FUNC_READ, 0, 0, bin_z1, 1, 0, 0, 0, 0, 1));
        dir_tab.push_back(row(FUNC_TRACE, 0, P_MAX, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, 30'sd80530636, 30'sd134217728, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, 30'sd69793218, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, -30'sd201326592, 30'sd26843545, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, -30'sd201326592, 30'sd2684354, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, -30'sd402653184, -30'sd510027366, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_TRACE, 30'sd100663296, P_MIN, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_READ, 0, 0, bin_z1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(FUNC_READ, P_MAX, P_MAX, 18'd131072, 0, 0, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        tx_pct = 28;
        rx_pct = 75;
        foreach (dir_tab[i])
            send_item(dir_tab[i]);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                1: write_limits(11'd0, 11'd0);
                2: write_limits(11'h7FF, 11'h7FF);
                3: write_limits(11'd5, 11'd1024);
                default: ;
            endcase
            case (ph)
                0: begin tx_pct = 28; rx_pct = 75; end
                1: begin tx_pct = 75; rx_pct = 28; end
                default: begin tx_pct = 0; rx_pct = 0; end
            endcase
            if (ph == 2) begin
                // long receiver hold-off while reads keep coming
                hold_req = 1;
                for (int i = 0; i < 20; i++)
                    send_item(rand_item(1));
            end
            for (int i = 0; i < 68; i++) begin
                if (ph == 3 && i == 30) begin
                    in_valid <= 0;
                    while (pending_q.size() != 0)
                        @(posedge clk);
                end
                send_item(rand_item(0));
            end
        end

        drain();
        if (errors == 0 && pending_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
